### sv/ccd_planar_ik_solver_top_assert.svh
// Assertion helpers for the planar CCD solver
`ifndef CCD_PLANAR_IK_SOLVER_TOP_ASSERT_SVH
`define CCD_PLANAR_IK_SOLVER_TOP_ASSERT_SVH

// same-cycle implication
`define CCD_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define CCD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/ccd_ik_pkg.sv
package ccd_ik_pkg;

    localparam int MAX_SEGMENTS   = 16;
    localparam int SEG_AW         = 4;
    localparam int CNT_W          = 5;
    localparam int MAX_SWEEPS     = 10;
    localparam int SWEEP_W        = 4;
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_W       = 36;
    localparam int ZW             = 22;
    localparam int CORDIC_X0      = 50940160;
    localparam int HALF_TURN_FINE = 524288;
    localparam int STEP_TENTH     = 6554;
    localparam int CONV_LIMIT     = 655;
    localparam int CONV_ABS_MAX   = 25;
    localparam int CFG_W          = 15;

    localparam logic REG_SEGMENT_COUNT  = 1'b0;
    localparam logic REG_MAX_ANGLE_STEP = 1'b1;

    localparam logic OP_SOLVE     = 1'b0;
    localparam logic OP_SET_ANGLE = 1'b1;

    typedef struct packed {
        logic                        start;
        logic                        vect;
        logic signed [CORDIC_W-1:0]  x;
        logic signed [CORDIC_W-1:0]  y;
        logic signed [ZW-1:0]        z;
    } t_cordic_req;

    // elementary angles in 2^-20 turn
    function automatic logic signed [ZW-1:0] cordic_atan(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 22'sd131072;
            4'd1:    v = 22'sd77376;
            4'd2:    v = 22'sd40884;
            4'd3:    v = 22'sd20753;
            4'd4:    v = 22'sd10417;
            4'd5:    v = 22'sd5213;
            4'd6:    v = 22'sd2607;
            4'd7:    v = 22'sd1304;
            4'd8:    v = 22'sd652;
            4'd9:    v = 22'sd326;
            4'd10:   v = 22'sd163;
            4'd11:   v = 22'sd81;
            4'd12:   v = 22'sd41;
            4'd13:   v = 22'sd20;
            4'd14:   v = 22'sd10;
            default: v = 22'sd5;
        endcase
        return v;
    endfunction

endpackage

### sv/ccd_ik_in_if.sv
interface ccd_ik_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [3:0]         segment_index;
    logic [15:0]        new_angle;

    modport source (output valid, opcode, target_x, target_y, segment_index, new_angle,
                    input ready);
    modport sink   (input valid, opcode, target_x, target_y, segment_index, new_angle,
                    output ready);
endinterface

### sv/ccd_ik_out_if.sv
interface ccd_ik_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] effector_x;
    logic signed [23:0] effector_y;
    logic [3:0]         sweeps_used;
    logic               converged;

    modport source (output valid, effector_x, effector_y, sweeps_used, converged,
                    input ready);
    modport sink   (input valid, effector_x, effector_y, sweeps_used, converged,
                    output ready);
endinterface

### sv/ccd_ik_cordic.sv
module ccd_ik_cordic (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ccd_ik_pkg::t_cordic_req                 i_req,
    output logic                                    o_done,
    output logic signed [ccd_ik_pkg::CORDIC_W-1:0]  o_x,
    output logic signed [ccd_ik_pkg::CORDIC_W-1:0]  o_y,
    output logic signed [ccd_ik_pkg::ZW-1:0]        o_z
);
    import ccd_ik_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic                       r_vect;
    logic [3:0]                 r_i;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [ZW-1:0]       r_z;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ZW-1:0]       ang;
    logic                       ccw;

    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        ang = cordic_atan(r_i);
        // rotation drives z to zero, vectoring drives y to zero
        ccw = r_vect ? r_y[CORDIC_W-1] : !r_z[ZW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vect <= i_req.vect;
            r_x    <= i_req.x;
            r_y    <= i_req.y;
            r_z    <= i_req.z;
        end else if (r_busy) begin
            if (ccw) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

### sv/ccd_planar_ik_solver_top.sv
// Channel   Dir  Handshake      Beat contents
// i_in      in   valid/ready    opcode, target_x, target_y, segment_index, new_angle
// o_out     out  valid/ready    effector_x, effector_y, sweeps_used, converged
// i_cfg_*   in   write enable   register index, data (no read-back)
//
// One item at a time. A solve step runs the one shared CORDIC unit four times
// for segments above 0 and three times for segment 0 (16-step runs, plus memory
// reads); each sweep adds one more run for the distance check. A solve stops
// after at most ten sweeps over up to 16 segments; a set-angle uses one run.
// Reset is synchronous, active low, and clears the per-entry valid bits so all
// entries read as zero. A stalled output holds in its register; the next beat
// is accepted meanwhile.
`include "ccd_planar_ik_solver_top_assert.svh"

module ccd_planar_ik_solver_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ccd_ik_in_if.sink                      i_in,
    ccd_ik_out_if.source                   o_out,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [ccd_ik_pkg::CFG_W-1:0]   i_cfg_data
);
    import ccd_ik_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_SETW   = 14'h0002,
        S_EPA    = 14'h0004,
        S_EPB    = 14'h0008,
        S_EPC    = 14'h0010,
        S_KRD    = 14'h0020,
        S_KLAT   = 14'h0040,
        S_VSTART = 14'h0080,
        S_VWAIT  = 14'h0100,
        S_DIFF   = 14'h0200,
        S_MUL    = 14'h0400,
        S_WR     = 14'h0800,
        S_CHK    = 14'h1000,
        S_OUT    = 14'h2000
    } t_state;

    // what the end-point evaluation feeds
    typedef enum logic [3:0] {
        PH_EFF  = 4'b0001,
        PH_PREV = 4'b0010,
        PH_CHK  = 4'b0100,
        PH_FIN  = 4'b1000
    } t_phase;

    t_state r_state;
    t_phase r_ph;

    // configuration
    logic [CNT_W-1:0]  r_cnt;
    logic [CFG_W-1:0]  r_lim;
    logic [CNT_W-1:0]  cfg_n;
    logic [SEG_AW-1:0] last;

    // item
    logic signed [23:0] r_tx, r_ty;
    logic [SEG_AW-1:0]  r_idx;
    logic [15:0]        r_nang;

    // solver working registers
    logic [SEG_AW-1:0]  r_k;
    logic [SEG_AW-1:0]  r_ep_addr;
    logic [SWEEP_W-1:0] r_sweep;
    logic               r_conv;
    logic signed [23:0] r_ex, r_ey;
    logic signed [23:0] r_px, r_py;
    logic signed [23:0] r_bx, r_by;
    logic signed [23:0] r_ebx, r_eby;
    logic               r_flip;
    logic [15:0]        r_ang;
    logic [15:0]        r_new_ang;
    logic               r_vsel;
    logic               r_vzero;
    logic signed [17:0] r_a1, r_a2;
    logic signed [15:0] r_d;

    // memories: angle and base, one entry per segment
    logic [15:0]        r_amem [MAX_SEGMENTS];
    logic [47:0]        r_bmem [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] r_avld, r_bvld;
    logic [15:0]        r_aq;
    logic [47:0]        r_bq;
    logic               r_av_q, r_bv_q;
    logic [SEG_AW-1:0]  rd_addr;
    logic               a_we, b_we;
    logic [SEG_AW-1:0]  a_wa;
    logic [15:0]        a_wd;

    // output register
    logic               r_out_valid;
    logic signed [23:0] r_ox, r_oy;
    logic [SWEEP_W-1:0] r_osw;
    logic               r_oconv;

    // CORDIC
    t_cordic_req                n_req;
    logic                       cd_done;
    logic signed [CORDIC_W-1:0] cd_x, cd_y;
    logic signed [ZW-1:0]       cd_z;

    // datapath temporaries
    logic [15:0]        e_ang;
    logic signed [23:0] e_bx, e_by;
    logic [15:0]        fold;
    logic signed [CORDIC_W-1:0] rx, ry;
    logic signed [23:0] cx, cy, end_x, end_y;
    logic signed [24:0] vdx, vdy;
    logic signed [CORDIC_W-1:0] vx, vy;
    logic signed [ZW-1:0] zr;
    logic signed [17:0] a_res;
    logic signed [19:0] dfull, lim20;
    logic signed [30:0] prod, prod_r;
    logic [15:0]        chg;
    logic signed [24:0] cdx, cdy;
    logic signed [5:0]  sdx, sdy;
    logic [11:0]        dist2;
    logic               conv_now;
    logic               set_hit;

    ccd_ik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_done  (cd_done),
        .o_x     (cd_x),
        .o_y     (cd_y),
        .o_z     (cd_z)
    );

    assign last    = SEG_AW'(r_cnt - CNT_W'(1));
    assign set_hit = ({1'b0, r_idx} < r_cnt);

    always_comb begin
        if (i_cfg_data[CNT_W-1:0] == '0)
            cfg_n = CNT_W'(1);
        else if (i_cfg_data[CNT_W-1:0] > CNT_W'(MAX_SEGMENTS))
            cfg_n = CNT_W'(MAX_SEGMENTS);
        else
            cfg_n = i_cfg_data[CNT_W-1:0];
    end

    // ---------------------------------------------------------------- memory
    assign rd_addr = (r_state == S_EPA) ? r_ep_addr : r_k;
    assign a_we    = (r_state == S_WR) || ((r_state == S_SETW) && set_hit);
    assign a_wa    = (r_state == S_WR) ? r_k : r_idx;
    assign a_wd    = (r_state == S_WR) ? r_new_ang : r_nang;
    assign b_we    = (r_state == S_WR);

    always_ff @(posedge i_clk) begin
        if (a_we)
            r_amem[a_wa] <= a_wd;
        r_aq <= r_amem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we)
            r_bmem[r_k] <= {r_px, r_py};
        r_bq <= r_bmem[rd_addr];
    end

    // an entry without its valid bit reads as zero
    assign e_ang = r_av_q ? r_aq : 16'd0;
    assign e_bx  = r_bv_q ? signed'(r_bq[47:24]) : 24'sd0;
    assign e_by  = r_bv_q ? signed'(r_bq[23:0])  : 24'sd0;

    // ---------------------------------------------------------------- datapath
    always_comb begin
        // fold the angle into a quarter turn either side of zero
        fold = (e_ang[15] ^ e_ang[14]) ? {~e_ang[15], e_ang[14:0]} : e_ang;

        // round to Q8 and undo the fold
        rx = cd_x + CORDIC_W'(32768);
        ry = cd_y + CORDIC_W'(32768);
        cx = {{4{rx[CORDIC_W-1]}}, rx[CORDIC_W-1:16]};
        cy = {{4{ry[CORDIC_W-1]}}, ry[CORDIC_W-1:16]};
        if (r_flip) begin
            cx = -cx;
            cy = -cy;
        end
        end_x = r_ebx + cx;
        end_y = r_eby + cy;

        // vector for the angle measurement
        if (r_vsel) begin
            vdx = 25'(r_ex) - 25'(r_bx);
            vdy = 25'(r_ey) - 25'(r_by);
        end else begin
            vdx = 25'(r_tx) - 25'(r_bx);
            vdy = 25'(r_ty) - 25'(r_by);
        end
        vx = {{3{vdx[24]}}, vdx, 8'd0};
        vy = {{3{vdy[24]}}, vdy, 8'd0};
        zr = '0;
        if (vdx[24]) begin
            zr = vdy[24] ? -ZW'(HALF_TURN_FINE) : ZW'(HALF_TURN_FINE);
            vx = -vx;
            vy = -vy;
        end

        a_res = r_vzero ? 18'sd0 : 18'((cd_z + ZW'(8)) >>> 4);

        // clamp the angle error
        lim20 = signed'({5'd0, r_lim});
        dfull = 20'(r_a1) - 20'(r_a2);
        if (dfull > lim20)
            dfull = lim20;
        else if (dfull < -lim20)
            dfull = -lim20;

        // scale by a tenth, round
        prod   = 31'(r_d) * 31'(STEP_TENTH);
        prod_r = prod + 31'(32768);
        chg    = {prod_r[30], prod_r[30:16]};

        // convergence; only small offsets can pass, so narrow squares do
        cdx  = 25'(r_ex) - 25'(r_tx);
        cdy  = 25'(r_ey) - 25'(r_ty);
        sdx  = cdx[5:0];
        sdy  = cdy[5:0];
        dist2 = 12'(sdx * sdx) + 12'(sdy * sdy);
        conv_now = (cdx >= -25'(CONV_ABS_MAX)) && (cdx <= 25'(CONV_ABS_MAX)) &&
                   (cdy >= -25'(CONV_ABS_MAX)) && (cdy <= 25'(CONV_ABS_MAX)) &&
                   (dist2 <= 12'(CONV_LIMIT));
    end

    always_comb begin
        n_req       = '0;
        n_req.start = (r_state == S_EPB) || (r_state == S_VSTART);
        n_req.vect  = (r_state == S_VSTART);
        if (r_state == S_VSTART) begin
            n_req.x = vx;
            n_req.y = vy;
            n_req.z = zr;
        end else begin
            n_req.x = CORDIC_W'(CORDIC_X0);
            n_req.y = '0;
            n_req.z = {{2{fold[15]}}, fold, 4'd0};
        end
    end

    // ---------------------------------------------------------------- control
    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= PH_FIN;
            r_cnt       <= CNT_W'(1);
            r_lim       <= CFG_W'(2048);
            r_avld      <= '0;
            r_bvld      <= '0;
            r_av_q      <= 1'b0;
            r_bv_q      <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_ep_addr   <= '0;
            r_sweep     <= '0;
            r_conv      <= 1'b0;
            r_vsel      <= 1'b0;
        end else begin
            r_av_q <= r_avld[rd_addr];
            r_bv_q <= r_bvld[rd_addr];
            if (a_we)
                r_avld[a_wa] <= 1'b1;
            if (b_we)
                r_bvld[r_k] <= 1'b1;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SEGMENT_COUNT: begin
                        r_cnt <= cfg_n;
                        // drop entries beyond the new count
                        for (int j = 0; j < MAX_SEGMENTS; j++) begin
                            if (CNT_W'(j) >= cfg_n) begin
                                r_avld[j] <= 1'b0;
                                r_bvld[j] <= 1'b0;
                            end
                        end
                    end
                    REG_MAX_ANGLE_STEP: r_lim <= i_cfg_data;
                endcase
            end

            // S_OUT owns the valid flag while it is loading a new beat
            if (o_out.ready && (r_state != S_OUT))
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sweep   <= '0;
                        r_conv    <= 1'b0;
                        r_k       <= last;
                        r_ep_addr <= last;
                        if (i_in.opcode == OP_SET_ANGLE) begin
                            r_state <= S_SETW;
                        end else begin
                            r_ph    <= PH_EFF;
                            r_state <= S_EPA;
                        end
                    end
                end
                S_SETW: begin
                    r_ph    <= PH_FIN;
                    r_state <= S_EPA;
                end
                S_EPA:  r_state <= S_EPB;
                S_EPB:  r_state <= S_EPC;
                S_EPC: begin
                    if (cd_done) begin
                        unique case (r_ph)
                            PH_EFF:  r_state <= S_KRD;
                            PH_PREV: r_state <= S_WR;
                            PH_CHK:  r_state <= S_CHK;
                            PH_FIN:  r_state <= S_OUT;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_KRD:  r_state <= S_KLAT;
                S_KLAT: begin
                    r_vsel  <= 1'b0;
                    r_state <= S_VSTART;
                end
                S_VSTART: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (cd_done) begin
                        r_vsel  <= 1'b1;
                        r_state <= r_vsel ? S_DIFF : S_VSTART;
                    end
                end
                S_DIFF: r_state <= S_MUL;
                S_MUL: begin
                    if (r_k != '0) begin
                        r_ep_addr <= r_k - SEG_AW'(1);
                        r_ph      <= PH_PREV;
                        r_state   <= S_EPA;
                    end else begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_ep_addr <= last;
                    r_state   <= S_EPA;
                    if (r_k == '0) begin
                        r_sweep <= r_sweep + SWEEP_W'(1);
                        r_ph    <= PH_CHK;
                    end else begin
                        r_k  <= r_k - SEG_AW'(1);
                        r_ph <= PH_EFF;
                    end
                end
                S_CHK: begin
                    r_conv <= conv_now;
                    if (conv_now || (r_sweep == SWEEP_W'(MAX_SWEEPS))) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k       <= last;
                        r_ep_addr <= last;
                        r_ph      <= PH_EFF;
                        r_state   <= S_EPA;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in.valid) begin
            r_tx   <= i_in.target_x;
            r_ty   <= i_in.target_y;
            r_idx  <= i_in.segment_index;
            r_nang <= i_in.new_angle;
        end
        if (r_state == S_EPB) begin
            r_ebx  <= e_bx;
            r_eby  <= e_by;
            r_flip <= e_ang[15] ^ e_ang[14];
        end
        if ((r_state == S_EPC) && cd_done) begin
            if (r_ph == PH_PREV) begin
                r_px <= end_x;
                r_py <= end_y;
            end else begin
                r_ex <= end_x;
                r_ey <= end_y;
            end
        end
        if (r_state == S_KLAT) begin
            r_ang <= e_ang;
            r_bx  <= e_bx;
            r_by  <= e_by;
        end
        if (r_state == S_VSTART)
            r_vzero <= (vdx == '0) && (vdy == '0);
        if ((r_state == S_VWAIT) && cd_done) begin
            if (r_vsel)
                r_a2 <= a_res;
            else
                r_a1 <= a_res;
        end
        if (r_state == S_DIFF)
            r_d <= dfull[15:0];
        if (r_state == S_MUL) begin
            r_new_ang <= r_ang + chg;
            // segment 0 keeps its own base
            if (r_k == '0) begin
                r_px <= r_bx;
                r_py <= r_by;
            end
        end
        if ((r_state == S_OUT) && (!r_out_valid || o_out.ready)) begin
            r_ox    <= r_ex;
            r_oy    <= r_ey;
            r_osw   <= r_sweep;
            r_oconv <= r_conv;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.effector_x  = r_ox;
    assign o_out.effector_y  = r_oy;
    assign o_out.sweeps_used = r_osw;
    assign o_out.converged   = r_oconv;

    // ---------------------------------------------------------------- checks
    `CCD_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1,
        (r_cnt >= CNT_W'(1)) && (r_cnt <= CNT_W'(MAX_SEGMENTS)),
        "segment count out of range")
    `CCD_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_state != S_IDLE, "accepted beat did not start work")
    `CCD_ASSERT_NOW(a_sweep_bound, i_clk, i_rst_n, r_out_valid,
        (o_out.sweeps_used <= SWEEP_W'(MAX_SWEEPS)) &&
        (!o_out.converged || (o_out.sweeps_used != '0)),
        "result sweep count inconsistent")
    `CCD_ASSERT_NOW(a_cordic_owner, i_clk, i_rst_n, cd_done,
        (r_state == S_EPC) || (r_state == S_VWAIT), "CORDIC result with no consumer")

endmodule
